### sv/assert_macros.svh
// Assertion macros shared by the RTL of the blit copy clipping block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every clock edge out of reset.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### sv/bcc_pkg.sv
// Shared constants of the blit copy clipping block.
// Depends on nothing; used by bcc_offset and blit_copy_clip_address.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index REG_BOUNDS_LEFT   = 3'd0;
    localparam t_cfg_index REG_BOUNDS_TOP    = 3'd1;
    localparam t_cfg_index REG_BOUNDS_SPAN_X = 3'd2;
    localparam t_cfg_index REG_BOUNDS_SPAN_Y = 3'd3;
    localparam t_cfg_index REG_ROW_STRIDE    = 3'd4;
    localparam t_cfg_index REG_SURFACE_READY = 3'd5;

    localparam int STAGES      = 7;
    localparam int OFFSET_BITS = 32;

    typedef logic [OFFSET_BITS-1:0] t_offset;

endpackage

`default_nettype wire

### sv/bcc_src_clip.sv
// Pipeline stages one and two: clips the source rectangle to the surface bounds
// and moves the destination corner along. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bcc_src_clip #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic [1:0]              i_load,
    input  wire logic [COORD_BITS-1:0]   i_src_left,
    input  wire logic [COORD_BITS-1:0]   i_src_top,
    input  wire logic [COORD_BITS-1:0]   i_src_span_x,
    input  wire logic [COORD_BITS-1:0]   i_src_span_y,
    input  wire logic [COORD_BITS-1:0]   i_dst_left,
    input  wire logic [COORD_BITS-1:0]   i_dst_top,
    input  wire logic [COORD_BITS-1:0]   i_bounds_left,
    input  wire logic [COORD_BITS-1:0]   i_bounds_top,
    input  wire logic [COORD_BITS-1:0]   i_bounds_span_x,
    input  wire logic [COORD_BITS-1:0]   i_bounds_span_y,
    input  wire logic                    i_surface_ready,
    output logic                         o_empty,
    output logic [COORD_BITS+1:0]        o_sx,
    output logic [COORD_BITS+1:0]        o_sy,
    output logic [COORD_BITS+1:0]        o_sw,
    output logic [COORD_BITS+1:0]        o_sh,
    output logic [COORD_BITS+1:0]        o_dx,
    output logic [COORD_BITS+1:0]        o_dy
);

    localparam int W = COORD_BITS + 2;

    logic [W-1:0] b_right;
    logic [W-1:0] b_bottom;
    logic [W-1:0] sx_w;
    logic [W-1:0] sy_w;
    logic [W-1:0] s_right;
    logic [W-1:0] s_bottom;
    logic         empty_in;

    logic         r1_empty;
    logic [W-1:0] r1_sx;
    logic [W-1:0] r1_sy;
    logic [W-1:0] r1_dx;
    logic [W-1:0] r1_dy;
    logic [W-1:0] r1_l;
    logic [W-1:0] r1_t;
    logic [W-1:0] r1_r;
    logic [W-1:0] r1_b;

    assign b_right  = W'(i_bounds_left) + W'(i_bounds_span_x);
    assign b_bottom = W'(i_bounds_top) + W'(i_bounds_span_y);
    assign sx_w     = W'(i_src_left);
    assign sy_w     = W'(i_src_top);
    assign s_right  = sx_w + W'(i_src_span_x);
    assign s_bottom = sy_w + W'(i_src_span_y);
    assign empty_in = !i_surface_ready || (i_bounds_span_x == '0) ||
                      (i_bounds_span_y == '0) || (i_src_span_x == '0) ||
                      (i_src_span_y == '0);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_empty <= empty_in;
            r1_sx    <= sx_w;
            r1_sy    <= sy_w;
            r1_dx    <= W'(i_dst_left);
            r1_dy    <= W'(i_dst_top);
            r1_l     <= (sx_w > W'(i_bounds_left)) ? sx_w : W'(i_bounds_left);
            r1_t     <= (sy_w > W'(i_bounds_top)) ? sy_w : W'(i_bounds_top);
            r1_r     <= (s_right < b_right) ? s_right : b_right;
            r1_b     <= (s_bottom < b_bottom) ? s_bottom : b_bottom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            o_empty <= r1_empty || (r1_r <= r1_l) || (r1_b <= r1_t);
            o_sx    <= r1_l;
            o_sy    <= r1_t;
            o_sw    <= r1_r - r1_l;
            o_sh    <= r1_b - r1_t;
            o_dx    <= r1_dx + (r1_l - r1_sx);
            o_dy    <= r1_dy + (r1_t - r1_sy);
        end
    end

endmodule

`default_nettype wire

### sv/bcc_dst_clip.sv
// Pipeline stages three and four: trims the destination on the left and top,
// then on the right and bottom. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bcc_dst_clip #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic [1:0]              i_load,
    input  wire logic [COORD_BITS-1:0]   i_bounds_left,
    input  wire logic [COORD_BITS-1:0]   i_bounds_top,
    input  wire logic [COORD_BITS-1:0]   i_bounds_span_x,
    input  wire logic [COORD_BITS-1:0]   i_bounds_span_y,
    input  wire logic                    i_empty,
    input  wire logic [COORD_BITS+1:0]   i_sx,
    input  wire logic [COORD_BITS+1:0]   i_sy,
    input  wire logic [COORD_BITS+1:0]   i_sw,
    input  wire logic [COORD_BITS+1:0]   i_sh,
    input  wire logic [COORD_BITS+1:0]   i_dx,
    input  wire logic [COORD_BITS+1:0]   i_dy,
    output logic                         o_empty,
    output logic [COORD_BITS+1:0]        o_sx,
    output logic [COORD_BITS+1:0]        o_sy,
    output logic [COORD_BITS+1:0]        o_sw,
    output logic [COORD_BITS+1:0]        o_sh,
    output logic [COORD_BITS+1:0]        o_dx,
    output logic [COORD_BITS+1:0]        o_dy
);

    localparam int W = COORD_BITS + 2;

    logic [W-1:0] bl_w;
    logic [W-1:0] bt_w;
    logic [W-1:0] trim_x;
    logic [W-1:0] trim_y;
    logic [W-1:0] b_right;
    logic [W-1:0] b_bottom;
    logic [W-1:0] d_right;
    logic [W-1:0] d_bottom;
    logic [W-1:0] r_edge;
    logic [W-1:0] b_edge;

    logic         r3_empty;
    logic [W-1:0] r3_sx;
    logic [W-1:0] r3_sy;
    logic [W-1:0] r3_sw;
    logic [W-1:0] r3_sh;
    logic [W-1:0] r3_dx;
    logic [W-1:0] r3_dy;

    assign bl_w   = W'(i_bounds_left);
    assign bt_w   = W'(i_bounds_top);
    assign trim_x = (i_dx < bl_w) ? (bl_w - i_dx) : '0;
    assign trim_y = (i_dy < bt_w) ? (bt_w - i_dy) : '0;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r3_empty <= i_empty || (trim_x >= i_sw) || (trim_y >= i_sh);
            r3_sx    <= i_sx + trim_x;
            r3_sy    <= i_sy + trim_y;
            r3_sw    <= i_sw - trim_x;
            r3_sh    <= i_sh - trim_y;
            r3_dx    <= i_dx + trim_x;
            r3_dy    <= i_dy + trim_y;
        end
    end

    assign b_right  = bl_w + W'(i_bounds_span_x);
    assign b_bottom = bt_w + W'(i_bounds_span_y);
    assign d_right  = r3_dx + r3_sw;
    assign d_bottom = r3_dy + r3_sh;
    assign r_edge   = (d_right < b_right) ? d_right : b_right;
    assign b_edge   = (d_bottom < b_bottom) ? d_bottom : b_bottom;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            o_empty <= r3_empty || (r_edge <= r3_dx) || (b_edge <= r3_dy);
            o_sx    <= r3_sx;
            o_sy    <= r3_sy;
            o_sw    <= r_edge - r3_dx;
            o_sh    <= b_edge - r3_dy;
            o_dx    <= r3_dx;
            o_dy    <= r3_dy;
        end
    end

endmodule

`default_nettype wire

### sv/bcc_offset.sv
// Pipeline stages five to seven: local coordinates, row times stride products,
// offset sums, overlap direction and the output register. Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_offset #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic [2:0]              i_load,
    input  wire logic [COORD_BITS-1:0]   i_bounds_left,
    input  wire logic [COORD_BITS-1:0]   i_bounds_top,
    input  wire logic [COORD_BITS-1:0]   i_row_stride,
    input  wire logic                    i_empty,
    input  wire logic [COORD_BITS+1:0]   i_sx,
    input  wire logic [COORD_BITS+1:0]   i_sy,
    input  wire logic [COORD_BITS+1:0]   i_sw,
    input  wire logic [COORD_BITS+1:0]   i_sh,
    input  wire logic [COORD_BITS+1:0]   i_dx,
    input  wire logic [COORD_BITS+1:0]   i_dy,
    output logic                         o_nothing_to_copy,
    output logic [COORD_BITS-1:0]        o_dst_left,
    output logic [COORD_BITS-1:0]        o_dst_top,
    output logic [COORD_BITS-1:0]        o_span_x,
    output logic [COORD_BITS-1:0]        o_span_y,
    output bcc_pkg::t_offset             o_src_pixel_offset,
    output bcc_pkg::t_offset             o_dst_pixel_offset,
    output logic                         o_rows_backwards
);

    localparam int C = COORD_BITS;
    localparam int W = COORD_BITS + 2;

    logic [W-1:0] slx_w;
    logic [W-1:0] sly_w;
    logic [W-1:0] dlx_w;
    logic [W-1:0] dly_w;

    logic         r5_empty;
    logic [C-1:0] r5_dx;
    logic [C-1:0] r5_dy;
    logic [C-1:0] r5_sw;
    logic [C-1:0] r5_sh;
    logic [C-1:0] r5_slx;
    logic [C-1:0] r5_sly;
    logic [C-1:0] r5_dlx;
    logic [C-1:0] r5_dly;

    logic             r6_empty;
    logic [C-1:0]     r6_dx;
    logic [C-1:0]     r6_dy;
    logic [C-1:0]     r6_sw;
    logic [C-1:0]     r6_sh;
    logic [C-1:0]     r6_slx;
    logic [C-1:0]     r6_dlx;
    bcc_pkg::t_offset r6_src_prod;
    bcc_pkg::t_offset r6_dst_prod;
    logic             r6_backwards;

    assign slx_w = i_sx - W'(i_bounds_left);
    assign sly_w = i_sy - W'(i_bounds_top);
    assign dlx_w = i_dx - W'(i_bounds_left);
    assign dly_w = i_dy - W'(i_bounds_top);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r5_empty <= i_empty;
            r5_dx    <= i_dx[C-1:0];
            r5_dy    <= i_dy[C-1:0];
            r5_sw    <= i_sw[C-1:0];
            r5_sh    <= i_sh[C-1:0];
            r5_slx   <= slx_w[C-1:0];
            r5_sly   <= sly_w[C-1:0];
            r5_dlx   <= dlx_w[C-1:0];
            r5_dly   <= dly_w[C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r6_empty     <= r5_empty;
            r6_dx        <= r5_dx;
            r6_dy        <= r5_dy;
            r6_sw        <= r5_sw;
            r6_sh        <= r5_sh;
            r6_slx       <= r5_slx;
            r6_dlx       <= r5_dlx;
            r6_src_prod  <= bcc_pkg::OFFSET_BITS'(r5_sly) *
                            bcc_pkg::OFFSET_BITS'(i_row_stride);
            r6_dst_prod  <= bcc_pkg::OFFSET_BITS'(r5_dly) *
                            bcc_pkg::OFFSET_BITS'(i_row_stride);
            r6_backwards <= (r5_dly > r5_sly) ||
                            ((r5_dly == r5_sly) && (r5_dlx > r5_slx));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            o_nothing_to_copy <= r6_empty;
            if (r6_empty) begin
                o_dst_left         <= '0;
                o_dst_top          <= '0;
                o_span_x           <= '0;
                o_span_y           <= '0;
                o_src_pixel_offset <= '0;
                o_dst_pixel_offset <= '0;
                o_rows_backwards   <= 1'b0;
            end else begin
                o_dst_left         <= r6_dx;
                o_dst_top          <= r6_dy;
                o_span_x           <= r6_sw;
                o_span_y           <= r6_sh;
                o_src_pixel_offset <= r6_src_prod + bcc_pkg::OFFSET_BITS'(r6_slx);
                o_dst_pixel_offset <= r6_dst_prod + bcc_pkg::OFFSET_BITS'(r6_dlx);
                o_rows_backwards   <= r6_backwards;
            end
        end
    end

endmodule

`default_nettype wire

### sv/blit_copy_clip_address.sv
// Blit copy clipping front end: seven register stages; each input transaction
// accepted at a clock edge passes through all of them to the output port.
// Throughput is one transaction per cycle while the output is not stalled; a stall
// holds each valid stage whose successor is still full, while empty stages ahead of it keep filling.
// Synchronous active-low reset clears the valid bits and the surface registers.
// Depends on bcc_pkg, bcc_src_clip, bcc_dst_clip, bcc_offset, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module blit_copy_clip_address #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire bcc_pkg::t_cfg_index     i_cfg_index,
    input  wire logic [COORD_BITS-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [COORD_BITS-1:0]   i_src_left,
    input  wire logic [COORD_BITS-1:0]   i_src_top,
    input  wire logic [COORD_BITS-1:0]   i_src_span_x,
    input  wire logic [COORD_BITS-1:0]   i_src_span_y,
    input  wire logic [COORD_BITS-1:0]   i_dst_left,
    input  wire logic [COORD_BITS-1:0]   i_dst_top,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_nothing_to_copy,
    output logic [COORD_BITS-1:0]        o_out_dst_left,
    output logic [COORD_BITS-1:0]        o_out_dst_top,
    output logic [COORD_BITS-1:0]        o_out_span_x,
    output logic [COORD_BITS-1:0]        o_out_span_y,
    output bcc_pkg::t_offset             o_src_pixel_offset,
    output bcc_pkg::t_offset             o_dst_pixel_offset,
    output logic                         o_rows_backwards
);

    localparam int NS = bcc_pkg::STAGES;
    localparam int W  = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_bounds_left;
    logic [COORD_BITS-1:0] r_bounds_top;
    logic [COORD_BITS-1:0] r_bounds_span_x;
    logic [COORD_BITS-1:0] r_bounds_span_y;
    logic [COORD_BITS-1:0] r_row_stride;
    logic                  r_surface_ready;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] stage_adv;

    logic         s2_empty;
    logic [W-1:0] s2_sx;
    logic [W-1:0] s2_sy;
    logic [W-1:0] s2_sw;
    logic [W-1:0] s2_sh;
    logic [W-1:0] s2_dx;
    logic [W-1:0] s2_dy;

    logic         s4_empty;
    logic [W-1:0] s4_sx;
    logic [W-1:0] s4_sy;
    logic [W-1:0] s4_sw;
    logic [W-1:0] s4_sh;
    logic [W-1:0] s4_dx;
    logic [W-1:0] s4_dy;

    logic         result_cleared;
    logic         span_missing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds_left   <= '0;
            r_bounds_top    <= '0;
            r_bounds_span_x <= '0;
            r_bounds_span_y <= '0;
            r_row_stride    <= '0;
            r_surface_ready <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bcc_pkg::REG_BOUNDS_LEFT:   r_bounds_left   <= i_cfg_data;
                bcc_pkg::REG_BOUNDS_TOP:    r_bounds_top    <= i_cfg_data;
                bcc_pkg::REG_BOUNDS_SPAN_X: r_bounds_span_x <= i_cfg_data;
                bcc_pkg::REG_BOUNDS_SPAN_Y: r_bounds_span_y <= i_cfg_data;
                bcc_pkg::REG_ROW_STRIDE:    r_row_stride    <= i_cfg_data;
                bcc_pkg::REG_SURFACE_READY: r_surface_ready <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        stage_adv[NS-1] = !r_valid[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_adv[k] = !r_valid[k] || stage_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_adv[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_in_ready  = stage_adv[0];
    assign o_out_valid = r_valid[NS-1];

    bcc_src_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_src_clip (
        .i_clk           (i_clk),
        .i_load          (stage_adv[1:0]),
        .i_src_left      (i_src_left),
        .i_src_top       (i_src_top),
        .i_src_span_x    (i_src_span_x),
        .i_src_span_y    (i_src_span_y),
        .i_dst_left      (i_dst_left),
        .i_dst_top       (i_dst_top),
        .i_bounds_left   (r_bounds_left),
        .i_bounds_top    (r_bounds_top),
        .i_bounds_span_x (r_bounds_span_x),
        .i_bounds_span_y (r_bounds_span_y),
        .i_surface_ready (r_surface_ready),
        .o_empty         (s2_empty),
        .o_sx            (s2_sx),
        .o_sy            (s2_sy),
        .o_sw            (s2_sw),
        .o_sh            (s2_sh),
        .o_dx            (s2_dx),
        .o_dy            (s2_dy)
    );

    bcc_dst_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_dst_clip (
        .i_clk           (i_clk),
        .i_load          (stage_adv[3:2]),
        .i_bounds_left   (r_bounds_left),
        .i_bounds_top    (r_bounds_top),
        .i_bounds_span_x (r_bounds_span_x),
        .i_bounds_span_y (r_bounds_span_y),
        .i_empty         (s2_empty),
        .i_sx            (s2_sx),
        .i_sy            (s2_sy),
        .i_sw            (s2_sw),
        .i_sh            (s2_sh),
        .i_dx            (s2_dx),
        .i_dy            (s2_dy),
        .o_empty         (s4_empty),
        .o_sx            (s4_sx),
        .o_sy            (s4_sy),
        .o_sw            (s4_sw),
        .o_sh            (s4_sh),
        .o_dx            (s4_dx),
        .o_dy            (s4_dy)
    );

    bcc_offset #(
        .COORD_BITS (COORD_BITS)
    ) u_offset (
        .i_clk              (i_clk),
        .i_load             (stage_adv[6:4]),
        .i_bounds_left      (r_bounds_left),
        .i_bounds_top       (r_bounds_top),
        .i_row_stride       (r_row_stride),
        .i_empty            (s4_empty),
        .i_sx               (s4_sx),
        .i_sy               (s4_sy),
        .i_sw               (s4_sw),
        .i_sh               (s4_sh),
        .i_dx               (s4_dx),
        .i_dy               (s4_dy),
        .o_nothing_to_copy  (o_nothing_to_copy),
        .o_dst_left         (o_out_dst_left),
        .o_dst_top          (o_out_dst_top),
        .o_span_x           (o_out_span_x),
        .o_span_y           (o_out_span_y),
        .o_src_pixel_offset (o_src_pixel_offset),
        .o_dst_pixel_offset (o_dst_pixel_offset),
        .o_rows_backwards   (o_rows_backwards)
    );

    assign result_cleared = (o_out_span_x == '0) && (o_out_span_y == '0) &&
                            (o_src_pixel_offset == '0) && !o_rows_backwards;
    assign span_missing   = (o_out_span_x == '0) || (o_out_span_y == '0);

    `ASSERT_CLKD(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready)
    `ASSERT_CLKD(a_empty_result_zeroed, i_clk, i_rst_n, o_out_valid && o_nothing_to_copy |-> result_cleared)
    `ASSERT_NEVER(a_copy_has_area, i_clk, i_rst_n, o_out_valid && !o_nothing_to_copy && span_missing)

endmodule

`default_nettype wire
